[src/cmbs_pkg.sv]
package cmbs_pkg;

  localparam int MAX_FACE_SIZE_DEF = 64;
  localparam int FACE_COUNT_DEF    = 6;
  localparam int DIR_W   = 16;
  localparam int MAG_W   = 17;
  localparam int Q_W     = 17;
  localparam int CH_W    = 8;
  localparam int TEXEL_W = 24;

  localparam logic [2:0] FACE_FRONT = 3'd0;
  localparam logic [2:0] FACE_BACK  = 3'd1;
  localparam logic [2:0] FACE_LEFT  = 3'd2;
  localparam logic [2:0] FACE_RIGHT = 3'd3;
  localparam logic [2:0] FACE_UP    = 3'd4;
  localparam logic [2:0] FACE_DOWN  = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] REG_FACE_SIZE = 2'd0;
  localparam logic [1:0] REG_LOADED    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  function automatic logic [CH_W-1:0] mix8(input logic [CH_W-1:0] p, input logic [CH_W-1:0] q,
                                           input logic [CH_W-1:0] k);
    logic [17:0] s;
    s = 18'(p) * (18'd256 - 18'(k)) + 18'(q) * 18'(k);
    return s[15:8];
  endfunction

endpackage

[src/cmbs_ram.sv]
module cmbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/cmbs_divider.sv]
// Pipelined restoring divider: quo = floor(num * 65536 / den), num <= den, den > 0.
// One quotient bit per stage, Q_W stages.
module cmbs_divider
  import cmbs_pkg::*;
#(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [MAG_W:0]   num,
  input  logic [MAG_W:0]   den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo,
  output logic [TAG_W-1:0] out_tag
);
  localparam int R_W = MAG_W + 2;

  logic             vld_r [Q_W];
  logic [R_W-1:0]   rem_r [Q_W];
  logic [MAG_W:0]   den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic             p_vld;
    logic [R_W-1:0]   p_rem;
    logic [MAG_W:0]   p_den;
    logic [Q_W-1:0]   p_q;
    logic [TAG_W-1:0] p_tag;
    logic [R_W-1:0]   sh;
    logic [R_W-1:0]   dif;
    logic             ge;
    if (i == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_rem = R_W'(num);
      assign p_den = den;
      assign p_q   = '0;
      assign p_tag = in_tag;
      assign sh    = p_rem;
    end else begin : g_next
      assign p_vld = vld_r[i-1];
      assign p_rem = rem_r[i-1];
      assign p_den = den_r[i-1];
      assign p_q   = q_r[i-1];
      assign p_tag = tag_r[i-1];
      assign sh    = {p_rem[R_W-2:0], 1'b0};
    end
    always_comb begin
      ge  = sh >= R_W'(p_den);
      dif = sh - R_W'(p_den);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= p_vld;
      end
      rem_r[i] <= ge ? dif : sh;
      den_r[i] <= p_den;
      q_r[i]   <= {p_q[Q_W-2:0], ge};
      tag_r[i] <= p_tag;
    end
  end

  assign out_vld = vld_r[Q_W-1];
  assign quo     = q_r[Q_W-1];
  assign out_tag = tag_r[Q_W-1];
endmodule

[src/cube_map_bilinear_sampler_top.sv]
// Cube map bilinear sampler.
// A lookup passes through the input stage, the 17-stage divider and 6 more stages before
// its result appears; out_valid is high for one cycle.
// Throughput: one transaction per cycle; busy stays low, writes give no result.
// Texels sit in four parity banks so all four bilinear taps are read in the same cycle;
// writes reach the banks through a delay line, in order with lookups.
// Reset: synchronous active-low; config and valid bits reset, texel store is not cleared.
module cube_map_bilinear_sampler_top
  import cmbs_pkg::*;
#(
  parameter int MAX_FACE_SIZE = MAX_FACE_SIZE_DEF,
  parameter int FACE_COUNT    = FACE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [2:0]           in_face,
  input  logic [5:0]           in_texel_x,
  input  logic [5:0]           in_texel_y,
  input  logic [7:0]           in_texel_red,
  input  logic [7:0]           in_texel_green,
  input  logic [7:0]           in_texel_blue,
  input  logic signed [15:0]   in_dir_x,
  input  logic signed [15:0]   in_dir_y,
  input  logic signed [15:0]   in_dir_z,
  output logic                 out_valid,
  output logic [7:0]           out_color_red,
  output logic [7:0]           out_color_green,
  output logic [7:0]           out_color_blue,
  output logic [2:0]           out_hit_face,
  output logic                 out_face_missing,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int CW   = $clog2(MAX_FACE_SIZE);
  localparam int SZW  = CW + 1;
  localparam int FW   = 3;
  localparam int BDEP = FACE_COUNT * ((MAX_FACE_SIZE + 1) / 2) * ((MAX_FACE_SIZE + 1) / 2);
  localparam int BAW  = $clog2(BDEP);
  localparam int HALF = (MAX_FACE_SIZE + 1) / 2;
  localparam int TAG_W = 2 + FW;
  localparam int WDLY = Q_W + 4;

  // configuration
  logic [6:0]  cfg_face_size_r;
  logic [5:0]  cfg_loaded_r;
  logic [14:0] cfg_thr_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_face_size_r <= 7'd64;
      cfg_loaded_r    <= '0;
      cfg_thr_r       <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FACE_SIZE: cfg_face_size_r <= pwdata[6:0];
        REG_LOADED:    cfg_loaded_r    <= pwdata[5:0];
        REG_THRESHOLD: cfg_thr_r       <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_FACE_SIZE: prdata = 32'(cfg_face_size_r);
      REG_LOADED:    prdata = 32'(cfg_loaded_r);
      REG_THRESHOLD: prdata = 32'(cfg_thr_r);
      default:       prdata = '0;
    endcase
  end

  logic [SZW-1:0] size_eff;
  always_comb begin
    if (cfg_face_size_r == 7'd0) begin
      size_eff = SZW'(1);
    end else if (32'(cfg_face_size_r) > 32'(MAX_FACE_SIZE)) begin
      size_eff = SZW'(MAX_FACE_SIZE);
    end else begin
      size_eff = SZW'(cfg_face_size_r);
    end
  end

  // write path into parity banks
  logic            acc;
  logic            wr_ok;
  logic [1:0]      wr_bank;
  logic [BAW-1:0]  wr_addr;
  assign acc   = start && !busy;
  assign wr_ok = acc && (in_operation == OP_WRITE) && (32'(in_face) < FACE_COUNT)
                 && (32'(in_texel_x) < MAX_FACE_SIZE) && (32'(in_texel_y) < MAX_FACE_SIZE);
  assign wr_bank = {in_texel_y[0], in_texel_x[0]};
  assign wr_addr = BAW'((32'(in_face) * HALF + 32'(in_texel_y >> 1)) * HALF
                        + 32'(in_texel_x >> 1));

  // writes trail by the lookup read latency so bank accesses keep transaction order
  logic               wq_v_r    [WDLY];
  logic [1:0]         wq_bank_r [WDLY];
  logic [BAW-1:0]     wq_addr_r [WDLY];
  logic [TEXEL_W-1:0] wq_data_r [WDLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WDLY; i++) begin
        wq_v_r[i] <= 1'b0;
      end
    end else begin
      wq_v_r[0] <= wr_ok;
      for (int i = 1; i < WDLY; i++) begin
        wq_v_r[i] <= wq_v_r[i-1];
      end
    end
    wq_bank_r[0] <= wr_bank;
    wq_addr_r[0] <= wr_addr;
    wq_data_r[0] <= {in_texel_red, in_texel_green, in_texel_blue};
    for (int i = 1; i < WDLY; i++) begin
      wq_bank_r[i] <= wq_bank_r[i-1];
      wq_addr_r[i] <= wq_addr_r[i-1];
      wq_data_r[i] <= wq_data_r[i-1];
    end
  end

  // stage 1: magnitudes and face choice
  logic            s1_v_r;
  logic [2:0]      s1_f_r;
  logic            s1_miss_r;
  logic [MAG_W:0]  s1_nu_r, s1_nw_r, s1_den_r;
  logic            s1_fu_r, s1_fw_r;

  logic [MAG_W-1:0] ax, ay, az;
  logic signed [16:0] thr_s;
  logic [2:0]  f1;
  logic signed [15:0] mj, mu, mw;
  logic [MAG_W-1:0] am;
  logic signed [17:0] su, sw;
  logic fu, fw;

  always_comb begin
    ax = in_dir_x[15] ? MAG_W'(-17'(in_dir_x)) : MAG_W'(in_dir_x);
    ay = in_dir_y[15] ? MAG_W'(-17'(in_dir_y)) : MAG_W'(in_dir_y);
    az = in_dir_z[15] ? MAG_W'(-17'(in_dir_z)) : MAG_W'(in_dir_z);
    thr_s = 17'(cfg_thr_r);
    if (ax >= ay && ax >= az) begin
      mj = in_dir_x; mu = in_dir_z; mw = in_dir_y;
      f1 = (17'(in_dir_x) > thr_s) ? FACE_RIGHT : FACE_LEFT;
    end else if (ay >= az) begin
      mj = in_dir_y; mu = in_dir_x; mw = in_dir_z;
      f1 = (17'(in_dir_y) > thr_s) ? FACE_UP : FACE_DOWN;
    end else begin
      mj = in_dir_z; mu = in_dir_x; mw = in_dir_y;
      f1 = (17'(in_dir_z) > thr_s) ? FACE_FRONT : FACE_BACK;
    end
    am = mj[15] ? MAG_W'(-17'(mj)) : MAG_W'(mj);
    su = mj[15] ? -18'(mu) : 18'(mu);
    sw = mj[15] ? -18'(mw) : 18'(mw);
    unique case (f1)
      FACE_RIGHT: begin fu = 1'b1; fw = 1'b0; end
      FACE_LEFT:  begin fu = 1'b1; fw = 1'b1; end
      FACE_UP:    begin fu = 1'b0; fw = 1'b1; end
      FACE_DOWN:  begin fu = 1'b1; fw = 1'b1; end
      FACE_FRONT: begin fu = 1'b0; fw = 1'b0; end
      default:    begin fu = 1'b0; fw = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc && (in_operation == OP_LOOKUP);
    end
    s1_f_r    <= f1;
    s1_miss_r <= (mj == 16'sd0) || !cfg_loaded_r[f1];
    s1_nu_r   <= (MAG_W+1)'(su + 18'(am));
    s1_nw_r   <= (MAG_W+1)'(sw + 18'(am));
    s1_den_r  <= (am == '0) ? (MAG_W+1)'(1) : {am, 1'b0};
    s1_fu_r   <= fu;
    s1_fw_r   <= fw;
  end

  logic            dv_u, dv_w;
  logic [Q_W-1:0]  qu, qw;
  logic [TAG_W-1:0] tag_u;
  logic [0:0]      tag_w;

  cmbs_divider #(.TAG_W(TAG_W)) u_div_u (
    .clk(clk), .rst_n(rst_n), .in_vld(s1_v_r), .num(s1_nu_r), .den(s1_den_r),
    .in_tag({s1_fu_r, s1_fw_r, s1_f_r}),
    .out_vld(dv_u), .quo(qu), .out_tag(tag_u));

  cmbs_divider #(.TAG_W(1)) u_div_w (
    .clk(clk), .rst_n(rst_n), .in_vld(s1_v_r), .num(s1_nw_r), .den(s1_den_r),
    .in_tag(s1_miss_r), .out_vld(dv_w), .quo(qw), .out_tag(tag_w));

  // stage 2: u, v
  logic           s2_v_r;
  logic [2:0]     s2_f_r;
  logic           s2_miss_r;
  logic [Q_W-1:0] s2_u_r, s2_v_q_r;
  logic [Q_W-1:0] w_full;

  always_comb begin
    w_full = tag_u[3] ? (Q_W'(17'h10000) - qw) : qw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= dv_u && dv_w;
    end
    s2_f_r    <= tag_u[2:0];
    s2_miss_r <= tag_w[0];
    s2_u_r    <= tag_u[4] ? (Q_W'(17'h10000) - qu) : qu;
    s2_v_q_r  <= Q_W'(17'h10000) - w_full;
  end

  // stage 3: scale by face size
  logic           s3_v_r;
  logic [2:0]     s3_f_r;
  logic           s3_miss_r;
  logic [Q_W+SZW-1:0] s3_pu_r, s3_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_f_r    <= s2_f_r;
    s3_miss_r <= s2_miss_r;
    s3_pu_r   <= (Q_W+SZW)'(s2_u_r) * (Q_W+SZW)'(size_eff);
    s3_pv_r   <= (Q_W+SZW)'(s2_v_q_r) * (Q_W+SZW)'(size_eff);
  end

  // stage 4: indices, clamp, bank addresses
  logic [SZW+1:0] c0w, r0w, c1w, r1w, limw;
  logic [CW-1:0]  c0, c1, r0, r1;

  always_comb begin
    limw = (SZW+2)'(size_eff) - (SZW+2)'(1);
    c0w = (SZW+2)'(s3_pu_r >> 16);
    r0w = (SZW+2)'(s3_pv_r >> 16);
    c1w = c0w + (SZW+2)'(1);
    r1w = r0w + (SZW+2)'(1);
    c0 = CW'((c0w > limw) ? limw : c0w);
    c1 = CW'((c1w > limw) ? limw : c1w);
    r0 = CW'((r0w > limw) ? limw : r0w);
    r1 = CW'((r1w > limw) ? limw : r1w);
  end

  logic           s4_v_r;
  logic [2:0]     s4_f_r;
  logic           s4_miss_r;
  logic [7:0]     s4_kc_r, s4_kr_r;
  logic [CW-1:0]  s4_c0_r, s4_c1_r, s4_r0_r, s4_r1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_f_r    <= s3_f_r;
    s4_miss_r <= s3_miss_r;
    s4_kc_r   <= s3_pu_r[15:8];
    s4_kr_r   <= s3_pv_r[15:8];
    s4_c0_r   <= c0;
    s4_c1_r   <= c1;
    s4_r0_r   <= r0;
    s4_r1_r   <= r1;
  end

  // bank read: each bank gets the tap with matching parity
  logic [CW-1:0] bc [4];
  logic [CW-1:0] br [4];
  logic [BAW-1:0] ra [4];
  logic [TEXEL_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    always_comb begin
      bc[b] = (s4_c0_r[0] == 1'(b & 1)) ? s4_c0_r : s4_c1_r;
      br[b] = (s4_r0_r[0] == 1'(b >> 1)) ? s4_r0_r : s4_r1_r;
      ra[b] = BAW'((32'(s4_f_r) * HALF + 32'(br[b] >> 1)) * HALF + 32'(bc[b] >> 1));
    end
    cmbs_ram #(.WIDTH(TEXEL_W), .DEPTH(BDEP)) u_bank (
      .clk(clk), .we(wq_v_r[WDLY-1] && (wq_bank_r[WDLY-1] == 2'(b))),
      .waddr(wq_addr_r[WDLY-1]), .wdata(wq_data_r[WDLY-1]),
      .raddr(ra[b]), .rdata(rd[b]));
  end

  // stage 5: read data valid
  logic           s5_v_r;
  logic [2:0]     s5_f_r;
  logic           s5_miss_r;
  logic [7:0]     s5_kc_r, s5_kr_r;
  logic           s5_c0p_r, s5_c1p_r, s5_r0p_r, s5_r1p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_f_r    <= s4_f_r;
    s5_miss_r <= s4_miss_r;
    s5_kc_r   <= s4_kc_r;
    s5_kr_r   <= s4_kr_r;
    s5_c0p_r  <= s4_c0_r[0];
    s5_c1p_r  <= s4_c1_r[0];
    s5_r0p_r  <= s4_r0_r[0];
    s5_r1p_r  <= s4_r1_r[0];
  end

  logic [TEXEL_W-1:0] t00, t10, t01, t11;
  always_comb begin
    t00 = rd[{s5_r0p_r, s5_c0p_r}];
    t10 = rd[{s5_r0p_r, s5_c1p_r}];
    t01 = rd[{s5_r1p_r, s5_c0p_r}];
    t11 = rd[{s5_r1p_r, s5_c1p_r}];
  end

  // stage 6: column blend
  logic           s6_v_r;
  logic [2:0]     s6_f_r;
  logic           s6_miss_r;
  logic [7:0]     s6_kr_r;
  logic [7:0]     s6_top_r [3];
  logic [7:0]     s6_bot_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_f_r    <= s5_f_r;
    s6_miss_r <= s5_miss_r;
    s6_kr_r   <= s5_kr_r;
    for (int ch = 0; ch < 3; ch++) begin
      s6_top_r[ch] <= mix8(t00[8*ch +: 8], t10[8*ch +: 8], s5_kc_r);
      s6_bot_r[ch] <= mix8(t01[8*ch +: 8], t11[8*ch +: 8], s5_kc_r);
    end
  end

  // stage 7: row blend and output register
  logic       out_v_r;
  logic [2:0] out_f_r;
  logic       out_m_r;
  logic [7:0] out_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= s6_v_r;
    end
    out_f_r <= s6_f_r;
    out_m_r <= s6_miss_r;
    for (int ch = 0; ch < 3; ch++) begin
      out_c_r[ch] <= s6_miss_r ? 8'd0 : mix8(s6_top_r[ch], s6_bot_r[ch], s6_kr_r);
    end
  end

  assign out_valid        = out_v_r;
  assign out_color_red    = out_c_r[2];
  assign out_color_green  = out_c_r[1];
  assign out_color_blue   = out_c_r[0];
  assign out_hit_face     = out_f_r;
  assign out_face_missing = out_m_r;
endmodule
